// ===== rtl/core/oet_pkg.sv =====
// Shared types, constants and codes for the ordered entry table.
package oet_pkg;

  // Table size and derived index and count widths.
  localparam int unsigned DEPTH = 64;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Operation codes.
  localparam logic [2:0] OP_INSERT    = 3'd0;
  localparam logic [2:0] OP_REMOVE    = 3'd1;
  localparam logic [2:0] OP_POP_FRONT = 3'd2;
  localparam logic [2:0] OP_POP_BACK  = 3'd3;
  localparam logic [2:0] OP_FIND      = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_POS   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_PICK = 3'b100
  } state_e;

  // One input item.
  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  position;
    logic [31:0] seq_key;
    logic [31:0] buf_addr;
    logic [15:0] buf_length;
    logic [15:0] cmd_code;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_seq;
    logic [31:0] out_addr;
    logic [15:0] out_length;
    logic [15:0] out_cmd;
    logic [6:0]  found_pos;
    logic [7:0]  entry_count;
  } out_item_t;

  // One stored record.
  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] addr;
    logic [15:0] length;
    logic [15:0] cmd;
  } rec_t;

  // Control broadcast to every cell of the row.
  typedef struct packed {
    logic             shift_up;
    logic             shift_down;
    logic [IDX_W-1:0] pos;
    rec_t             new_rec;
  } cell_ctl_t;

endpackage

// ===== rtl/core/oet_cell.sv =====
// One cell of the table row: holds a record, shifts with its neighbors, compares a key.
module oet_cell import oet_pkg::*; (
  input  logic             clk_i,
  input  logic [IDX_W-1:0] idx_i,
  input  cell_ctl_t        ctl_i,
  input  rec_t             lower_i,
  input  rec_t             upper_i,
  input  logic [31:0]      key_i,
  input  logic [CNT_W-1:0] count_i,
  output rec_t             rec_o,
  output logic             match_o
);

  rec_t rec_q;
  logic match_q;

  // Insert moves records up from the lower neighbor; remove pulls them down from the upper one.
  always_ff @(posedge clk_i) begin
    if (ctl_i.shift_up) begin
      if (idx_i > ctl_i.pos) begin
        rec_q <= lower_i;
      end else if (idx_i == ctl_i.pos) begin
        rec_q <= ctl_i.new_rec;
      end
    end else if (ctl_i.shift_down && (idx_i >= ctl_i.pos)) begin
      rec_q <= upper_i;
    end
  end

  // The key compare is registered; only cells below the fill count may hit.
  always_ff @(posedge clk_i) begin
    match_q <= (rec_q.seq == key_i) && (CNT_W'(idx_i) < count_i);
  end

  assign rec_o   = rec_q;
  assign match_o = match_q;

endmodule

// ===== rtl/core/oet_chain.sv =====
// Row of table cells with the first-hit pick and the record read mux.
module oet_chain import oet_pkg::*; (
  input  logic             clk_i,
  input  cell_ctl_t        ctl_i,
  input  logic [31:0]      key_i,
  input  logic [CNT_W-1:0] count_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  output rec_t             rd_rec_o,
  output logic             hit_o,
  output logic [IDX_W-1:0] hit_idx_o
);

  rec_t       recs  [DEPTH];
  logic [DEPTH-1:0] match;

  // Each cell sees the records of both neighbors; the ends see their own.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    rec_t lower;
    rec_t upper;

    if (k == 0) begin : g_first
      assign lower = recs[k];
    end else begin : g_inner_lo
      assign lower = recs[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign upper = recs[k];
    end else begin : g_inner_hi
      assign upper = recs[k+1];
    end

    oet_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(k)),
      .ctl_i   (ctl_i),
      .lower_i (lower),
      .upper_i (upper),
      .key_i   (key_i),
      .count_i (count_i),
      .rec_o   (recs[k]),
      .match_o (match[k])
    );
  end

  // Lowest matching position wins.
  always_comb begin
    hit_o     = 1'b0;
    hit_idx_o = '0;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if (match[k]) begin
        hit_o     = 1'b1;
        hit_idx_o = IDX_W'(k);
      end
    end
  end

  assign rd_rec_o = recs[rd_idx_i];

endmodule

// ===== rtl/core/ordered_entry_table.sv =====
// Ordered table of send records: insert, remove, pop front, pop back and find by key.
//
// Input channel: in_valid_i, in_item_i, in_stall_o. An item is one operation and is
// accepted at an edge with in_valid_i high and in_stall_o low. Output channel:
// out_valid_o, out_item_o, out_stall_i. Every item gives exactly one result item.
// The records sit in a row of cells that all shift together, so insert, remove and
// the pops commit from S_EXEC once the output register is free; a new item is
// accepted only in S_IDLE, after the last one commits. Find registers the compare
// of every cell in S_EXEC and picks the lowest hit in S_PICK before it commits.
// A result waits in the output register while the receiver stalls; the next item
// is still accepted and worked up to its commit, which waits until the output
// register is free, so the table never runs ahead of the delivered results.
// Reset empties the table (fill count zero) and drops any result in flight; the
// record storage itself is not cleared and needs no clearing pass.
module ordered_entry_table import oet_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  in_item_t  in_item_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  output out_item_t out_item_o,
  input  logic      out_stall_i
);

  state_e           state_q, state_d;
  in_item_t         in_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q;

  cell_ctl_t        op_ctl, ctl;
  out_item_t        res;
  logic [CNT_W-1:0] cnt_next;
  logic [IDX_W-1:0] rd_idx;
  logic             take_rec;
  logic             to_pick;
  logic             done;
  logic             out_free;
  rec_t             rd_rec;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [8:0]       pos_ext;
  logic [8:0]       cnt_ext;
  logic [CNT_W-1:0] cnt_m1;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pos_ext  = {1'b0, in_q.position};
  assign cnt_ext  = 9'(count_q);
  assign cnt_m1   = count_q - CNT_W'(1);

  // Decode the held operation into cell control and a result.
  always_comb begin
    op_ctl         = '0;
    op_ctl.new_rec = '{seq: in_q.seq_key, addr: in_q.buf_addr,
                       length: in_q.buf_length, cmd: in_q.cmd_code};
    res      = '0;
    cnt_next = count_q;
    rd_idx   = '0;
    take_rec = 1'b0;
    to_pick  = 1'b0;
    res.status = ST_OK;

    if (state_q == S_PICK) begin
      // Find: the match vector was registered in the previous cycle.
      rd_idx = hit_idx;
      if (count_q == '0) begin
        res.status = ST_BAD_POS;
      end else if (hit) begin
        take_rec      = 1'b1;
        res.found_pos = 7'(hit_idx);
      end else begin
        res.status = ST_NOT_FOUND;
      end
    end else begin
      case (in_q.opcode)
        OP_INSERT: begin
          if (count_q == CNT_W'(DEPTH)) begin
            res.status = ST_FULL;
          end else begin
            op_ctl.shift_up = 1'b1;
            op_ctl.pos      = (pos_ext > cnt_ext) ? IDX_W'(count_q)
                                                  : IDX_W'(in_q.position);
            cnt_next        = count_q + CNT_W'(1);
          end
        end
        OP_REMOVE: begin
          if (pos_ext >= cnt_ext) begin
            res.status = ST_BAD_POS;
          end else begin
            rd_idx   = IDX_W'(in_q.position);
            take_rec = 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (count_q == '0) begin
            res.status = ST_BAD_POS;
          end else begin
            rd_idx   = '0;
            take_rec = 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (count_q == '0) begin
            res.status = ST_BAD_POS;
          end else begin
            rd_idx   = IDX_W'(cnt_m1);
            take_rec = 1'b1;
          end
        end
        OP_FIND: begin
          to_pick = 1'b1;
        end
        default: begin
          res.status = ST_BAD_POS;
        end
      endcase

      // Every removal closes the gap at the read position.
      if (take_rec) begin
        op_ctl.shift_down = 1'b1;
        op_ctl.pos        = rd_idx;
        cnt_next          = cnt_m1;
      end
    end

    if (take_rec) begin
      res.out_seq    = rd_rec.seq;
      res.out_addr   = rd_rec.addr;
      res.out_length = rd_rec.length;
      res.out_cmd    = rd_rec.cmd;
    end
    res.entry_count = 8'(cnt_next);
  end

  // Sequencer: commit an operation only when its result has a free slot.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    ctl         = op_ctl;
    done        = 1'b0;
    ctl.shift_up   = 1'b0;
    ctl.shift_down = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (to_pick) begin
          state_d = S_PICK;
        end else if (out_free) begin
          done = 1'b1;
        end
      end
      S_PICK: begin
        if (out_free) begin
          done = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (done) begin
      state_d        = S_IDLE;
      count_d        = cnt_next;
      out_valid_d    = 1'b1;
      ctl.shift_up   = op_ctl.shift_up;
      ctl.shift_down = op_ctl.shift_down;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Held operation and output payload.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      in_q <= in_item_i;
    end
    if (done) begin
      out_q <= res;
    end
  end

  oet_chain u_chain (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .key_i     (in_q.seq_key),
    .count_i   (count_q),
    .rd_idx_i  (rd_idx),
    .rd_rec_o  (rd_rec),
    .hit_o     (hit),
    .hit_idx_o (hit_idx)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== dv/tb_ordered_entry_table.sv =====
// Testbench for the ordered entry table: random traffic checked against a local table predictor.
module tb_ordered_entry_table import oet_pkg::*; ();

  // Opcodes with no operation behind them.
  localparam logic [2:0] OP_SPARE_FIRST = OP_FIND + 3'd1;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  // Cycles without any accepted item before the run is declared hung.
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  // Cycles allowed after the last result for anything left in the pipe.
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  in_item_t  in_item_i = '0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_item_o;
  logic      out_stall_i = 1'b0;

  ordered_entry_table u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

  // Predicted table contents and the results still owed by the block.
  rec_t        table_rec [DEPTH];
  int unsigned table_cnt = 0;
  out_item_t   expected_results [$];

  // Run statistics.
  int unsigned err_cnt = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_full_refused = 0;
  int unsigned n_bad_pos = 0;
  int unsigned n_not_found = 0;
  int unsigned n_full_reached = 0;
  int unsigned n_emptied = 0;

  // Sender burst bookkeeping, receiver stall pattern and watchdog.
  int unsigned burst_left = 0;
  stall_mode_e stall_mode = STALL_NONE;
  logic [7:0]  stall_cyc = '0;
  int unsigned idle_cycles = 0;

  // Clock with a period of 10.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Removes the record at idx from the predicted table and reports it.
  function automatic out_item_t table_take(input int unsigned idx);
    out_item_t   r;
    int unsigned i;
    r = '0;
    r.status     = ST_OK;
    r.out_seq    = table_rec[idx].seq;
    r.out_addr   = table_rec[idx].addr;
    r.out_length = table_rec[idx].length;
    r.out_cmd    = table_rec[idx].cmd;
    for (i = idx; i + 1 < table_cnt; i++) begin
      table_rec[i] = table_rec[i + 1];
    end
    table_cnt--;
    return r;
  endfunction

  // Applies one operation to the predicted table and returns the result it owes.
  function automatic out_item_t table_apply(input in_item_t it);
    out_item_t   r;
    int unsigned p;
    int unsigned i;
    logic        hit;
    r   = '0;
    hit = 1'b0;
    case (it.opcode)
      OP_INSERT: begin
        if (table_cnt >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // A position past the count appends.
          p = it.position;
          if (p > table_cnt) p = table_cnt;
          for (i = table_cnt; i > p; i--) begin
            table_rec[i] = table_rec[i - 1];
          end
          table_rec[p] = '{it.seq_key, it.buf_addr, it.buf_length, it.cmd_code};
          table_cnt++;
          r.status = ST_OK;
        end
      end
      OP_REMOVE: begin
        if (it.position >= table_cnt) r.status = ST_BAD_POS;
        else r = table_take(it.position);
      end
      OP_POP_FRONT: begin
        if (table_cnt == 0) r.status = ST_BAD_POS;
        else r = table_take(0);
      end
      OP_POP_BACK: begin
        if (table_cnt == 0) r.status = ST_BAD_POS;
        else r = table_take(table_cnt - 1);
      end
      OP_FIND: begin
        if (table_cnt == 0) begin
          r.status = ST_BAD_POS;
        end else begin
          // The lowest matching position wins.
          r.status = ST_NOT_FOUND;
          for (i = 0; i < table_cnt; i++) begin
            if (!hit && table_rec[i].seq == it.seq_key) begin
              hit          = 1'b1;
              r.status     = ST_OK;
              r.out_seq    = table_rec[i].seq;
              r.out_addr   = table_rec[i].addr;
              r.out_length = table_rec[i].length;
              r.out_cmd    = table_rec[i].cmd;
              r.found_pos  = 7'(i);
            end
          end
        end
      end
      default: begin
        r.status = ST_BAD_POS;
      end
    endcase
    r.entry_count = 8'(table_cnt);
    return r;
  endfunction

  function automatic in_item_t make_item(input logic [2:0] op, input logic [7:0] pos,
                                         input logic [31:0] key, input logic [31:0] addr,
                                         input logic [15:0] len, input logic [15:0] cmd);
    in_item_t it;
    it.opcode     = op;
    it.position   = pos;
    it.seq_key    = key;
    it.buf_addr   = addr;
    it.buf_length = len;
    it.cmd_code   = cmd;
    return it;
  endfunction

  // Sends one item, with a random gap at the start of most bursts, and records its result.
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    out_item_t   r;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    end
    burst_left--;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    r = table_apply(it);
    expected_results.push_back(r);
    n_sent++;
    if (r.status == ST_FULL) n_full_refused++;
    if (r.status == ST_BAD_POS) n_bad_pos++;
    if (r.status == ST_NOT_FOUND) n_not_found++;
    if (it.opcode == OP_INSERT && r.status == ST_OK && r.entry_count == DEPTH)
      n_full_reached++;
    if (it.opcode != OP_INSERT && r.status == ST_OK && r.entry_count == 0 &&
        it.opcode != OP_FIND)
      n_emptied++;
  endtask

  // Builds one random operation; ins_pct sets how often it is an insert.
  task automatic random_item(input int unsigned ins_pct);
    in_item_t    it;
    int unsigned pick;
    it = make_item(OP_INSERT, 8'($urandom_range(0, 255)), $urandom, $urandom,
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    // A few small keys make duplicate sequence numbers likely.
    if ($urandom_range(0, 3) == 0) it.seq_key = $urandom_range(0, 7);
    if ($urandom_range(0, 99) < ins_pct) begin
      if ($urandom_range(0, 9) < 7) it.position = 8'($urandom_range(0, table_cnt));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        it.opcode = OP_REMOVE;
        if ($urandom_range(0, 4) != 0)
          it.position = 8'($urandom_range(0, (table_cnt == 0) ? 0 : table_cnt - 1));
      end else if (pick < 55) begin
        it.opcode = OP_POP_FRONT;
      end else if (pick < 75) begin
        it.opcode = OP_POP_BACK;
      end else if (pick < 97) begin
        it.opcode = OP_FIND;
        // Mostly search for a key that is present.
        if (table_cnt != 0 && $urandom_range(0, 4) != 0)
          it.seq_key = table_rec[$urandom_range(0, table_cnt - 1)].seq;
      end else begin
        it.opcode = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      end
    end
    send_item(it);
  endtask

  // Every operation but insert on an empty table, including the unused opcodes.
  task automatic test_empty_table();
    send_item(make_item(OP_POP_FRONT, 8'd0, 32'd0, 32'd0, 16'd0, 16'd0));
    send_item(make_item(OP_POP_BACK, 8'd0, 32'd0, 32'd0, 16'd0, 16'd0));
    send_item(make_item(OP_REMOVE, 8'd0, 32'd0, 32'd0, 16'd0, 16'd0));
    send_item(make_item(OP_REMOVE, 8'hFF, '1, '1, '1, '1));
    send_item(make_item(OP_FIND, 8'd0, 32'd0, 32'd0, 16'd0, 16'd0));
    send_item(make_item(OP_FIND, 8'hFF, '1, '1, '1, '1));
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) begin
      send_item(make_item(3'(op), 8'hFF, '1, '1, '1, '1));
    end
  endtask

  // Inserts at the front, middle and past the end, then searches with hits,
  // a duplicate key and a miss.
  task automatic test_insert_find();
    send_item(make_item(OP_INSERT, 8'hFF, '1, '1, '1, '1));
    send_item(make_item(OP_INSERT, 8'd0, 32'd0, 32'd0, 16'd0, 16'd0));
    send_item(make_item(OP_INSERT, 8'd1, 32'h1234, 32'hA5A5_0001, 16'h00FF, 16'h8001));
    send_item(make_item(OP_INSERT, 8'd2, 32'h1234, 32'h5A5A_0002, 16'hFF00, 16'h0102));
    send_item(make_item(OP_FIND, 8'd0, 32'h1234, 32'd0, 16'd0, 16'd0));
    send_item(make_item(OP_FIND, 8'd0, 32'd0, 32'd0, 16'd0, 16'd0));
    send_item(make_item(OP_FIND, 8'd0, '1, 32'd0, 16'd0, 16'd0));
    send_item(make_item(OP_FIND, 8'd0, 32'h5555, 32'd0, 16'd0, 16'd0));
  endtask

  // Removes at the count, in the middle, and pops both ends until empty.
  task automatic test_remove_ops();
    send_item(make_item(OP_REMOVE, 8'd4, 32'd0, 32'd0, 16'd0, 16'd0));
    send_item(make_item(OP_REMOVE, 8'd1, 32'd0, 32'd0, 16'd0, 16'd0));
    send_item(make_item(OP_POP_BACK, 8'd0, 32'd0, 32'd0, 16'd0, 16'd0));
    send_item(make_item(OP_POP_FRONT, 8'd0, 32'd0, 32'd0, 16'd0, 16'd0));
    send_item(make_item(OP_POP_FRONT, 8'd0, 32'd0, 32'd0, 16'd0, 16'd0));
  endtask

  // Insert-heavy traffic that drives the table into its full state.
  task automatic test_random_fill(input int unsigned n);
    repeat (n) random_item(75);
  endtask

  // Remove-heavy traffic that drains the table back to empty.
  task automatic test_random_drain(input int unsigned n);
    repeat (n) random_item(20);
  endtask

  // Balanced traffic around the middle of the table.
  task automatic test_random_mixed(input int unsigned n);
    repeat (n) random_item(50);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, got_v);
      err_cnt++;
    end
  endtask

  task automatic compare_result(input out_item_t exp_r, input out_item_t got);
    check_field("status", exp_r.status, got.status);
    check_field("out_seq", exp_r.out_seq, got.out_seq);
    check_field("out_addr", exp_r.out_addr, got.out_addr);
    check_field("out_length", exp_r.out_length, got.out_length);
    check_field("out_cmd", exp_r.out_cmd, got.out_cmd);
    check_field("found_pos", exp_r.found_pos, got.found_pos);
    check_field("entry_count", exp_r.entry_count, got.entry_count);
  endtask

  // Each accepted result is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_checked++;
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected: expected nothing, actual %h",
                 $time, out_item_o);
        err_cnt++;
      end else begin
        compare_result(expected_results.pop_front(), out_item_o);
      end
    end
  end

  // The receiver picks a new random stall pattern whenever the low six bits of its counter are zero.
  always @(posedge clk_i) begin
    stall_cyc <= stall_cyc + 8'd1;
    if (stall_cyc[5:0] == 6'd0) stall_mode <= stall_mode_e'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:     out_stall_i <= (stall_cyc[3:0] < 4'd9);
    endcase
  end

  // The watchdog ends a run in which nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item accepted for %0d cycles", $time, idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_insert_find();
    test_remove_ops();
    repeat (3) begin
      test_random_fill(150);
      test_random_drain(150);
    end
    test_random_mixed(200);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d operations and checked %0d results; %0d inserts refused as full,",
             n_sent, n_checked, n_full_refused);
    $display("%0d bad-position or empty errors, %0d failed searches, %0d fills, %0d drains.",
             n_bad_pos, n_not_found, n_full_reached, n_emptied);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
